// ===== rtl/sdfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Scale display frame decoder package
// Frame layout constants, character codes and shared types.
// ----------------------------------------------------------------------------
package sdfd_pkg;

    // Frame geometry.
    localparam int FRAME_LENGTH = 24;
    localparam int POS_W        = 5;
    localparam int DIGIT_FIRST  = 4;
    localparam int DIGIT_COUNT  = 5;
    localparam int TRAILER_FIRST = FRAME_LENGTH - 4;
    localparam int CHAR_W       = 5;
    localparam int OUT_W        = 32;

    // Fixed header and trailer bytes.
    localparam logic [7:0] HEADER_BYTES [4]  = '{8'h04, 8'h02, 8'h08, 8'h20};
    localparam logic [7:0] TRAILER_BYTES [4] = '{8'h06, 8'h82, 8'h48, 8'h28};

    // Character codes beyond the hex digits.
    localparam logic [CHAR_W-1:0] CH_U       = 5'd16;
    localparam logic [CHAR_W-1:0] CH_O       = 5'd17;
    localparam logic [CHAR_W-1:0] CH_DASH    = 5'd18;
    localparam logic [CHAR_W-1:0] CH_N       = 5'd19;
    localparam logic [CHAR_W-1:0] CH_L       = 5'd20;
    localparam logic [CHAR_W-1:0] CH_EQUAL   = 5'd21;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 5'd22;
    localparam logic [CHAR_W-1:0] CH_UNKNOWN = 5'd23;

    // One decoded display digit.
    typedef struct packed {
        logic              point;
        logic [CHAR_W-1:0] ch;
    } seg_dec_t;

endpackage

// ===== rtl/scale_display_frame_decoder.sv =====
// After the last frame byte is accepted, done_reg is set, then the word enters the output queue.
// Throughput: one byte per cycle while s_tready is high; counter and segment tables act at once.
// A result may be issued at most once per 24 bytes; a two-word output queue absorbs stalls.
// Reset (aresetn low, synchronous) sets the counter idle until a burst start and empties
// the output queue; the digit byte registers are not reset.
// ----------------------------------------------------------------------------
// Scale display frame decoder
// Checks the header and trailer of each 24-byte burst and decodes its digits.
// ----------------------------------------------------------------------------
module scale_display_frame_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    input  logic                         s_tuser,   // [0] burst_start
    // Result stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [4:0] char0, [9:5] char1, [14:10] char2, [19:15] char3, [24:20] char4,
    // [25] point1, [26] point2, [27] point3, [28] tare_on, [29] zero_on, [31:30] zero
    output logic [sdfd_pkg::OUT_W-1:0]   m_tdata
);

    localparam int PW = sdfd_pkg::POS_W;

    logic [PW-1:0] pos_reg, pos_next;
    logic          hdr_reg, hdr_next;
    logic          trl_reg, trl_next;
    logic          done_reg, done_next;
    logic [7:0]    digit_reg [sdfd_pkg::DIGIT_COUNT];

    logic [PW-1:0] pos_eff;
    logic          hdr_eff, trl_eff;
    logic          accept;
    logic          in_frame;
    logic          digit_we;
    logic [2:0]    digit_idx;

    logic                       out_valid_reg, out_valid_next;
    logic [sdfd_pkg::OUT_W-1:0] out_data_reg, out_data_next;
    logic                       skid_valid_reg, skid_valid_next;
    logic [sdfd_pkg::OUT_W-1:0] skid_data_reg, skid_data_next;
    logic [sdfd_pkg::OUT_W-1:0] new_word;

    sdfd_pkg::seg_dec_t dec [sdfd_pkg::DIGIT_COUNT];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;

    // Frame position and check flags as seen by the current byte.
    always_comb begin
        pos_eff   = s_tuser ? '0 : pos_reg;
        hdr_eff   = s_tuser ? 1'b1 : hdr_reg;
        trl_eff   = s_tuser ? 1'b1 : trl_reg;
        in_frame  = pos_eff < PW'(sdfd_pkg::FRAME_LENGTH);
        digit_we  = accept && (pos_eff >= PW'(sdfd_pkg::DIGIT_FIRST))
                    && (pos_eff < PW'(sdfd_pkg::DIGIT_FIRST + sdfd_pkg::DIGIT_COUNT));
        digit_idx = 3'(pos_eff - PW'(sdfd_pkg::DIGIT_FIRST));
    end

    // Next frame state on each accepted byte.
    always_comb begin
        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        trl_next  = trl_reg;
        done_next = 1'b0;
        if (accept) begin
            pos_next = pos_eff;
            hdr_next = hdr_eff;
            trl_next = trl_eff;
            if (in_frame) begin
                pos_next = pos_eff + PW'(1);
                if (pos_eff < PW'(4) && s_tdata != sdfd_pkg::HEADER_BYTES[pos_eff[1:0]]) begin
                    hdr_next = 1'b0;
                end
                if (pos_eff >= PW'(sdfd_pkg::TRAILER_FIRST)
                    && s_tdata != sdfd_pkg::TRAILER_BYTES[pos_eff[1:0]]) begin
                    trl_next = 1'b0;
                end
                done_next = (pos_eff == PW'(sdfd_pkg::FRAME_LENGTH - 1)) && hdr_next && trl_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= PW'(sdfd_pkg::FRAME_LENGTH);
            hdr_reg  <= 1'b0;
            trl_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            trl_reg  <= trl_next;
            done_reg <= done_next;
        end
    end

    // Digit byte capture; no reset, every entry is written before a frame ends.
    always_ff @(posedge aclk) begin
        if (digit_we) begin
            digit_reg[digit_idx] <= s_tdata;
        end
    end

    // Segment decoders, one per digit byte.
    for (genvar k = 0; k < sdfd_pkg::DIGIT_COUNT; k++) begin : g_dec
        sdfd_seg_decode u_dec (
            .code (digit_reg[k]),
            .dec  (dec[k])
        );
    end

    // Pack the result word.
    assign new_word = {2'b00, dec[4].point, dec[0].point, dec[3].point, dec[2].point,
                       dec[1].point, dec[4].ch, dec[3].ch, dec[2].ch, dec[1].ch, dec[0].ch};

    // Two-word output queue: output register with a skid slot behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = done_reg;
                skid_data_next  = new_word;
            end else begin
                out_valid_next = done_reg;
                out_data_next  = new_word;
            end
        end else if (done_reg) begin
            skid_valid_next = 1'b1;
            skid_data_next  = new_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/sdfd_seg_decode.sv =====
// ----------------------------------------------------------------------------
// Seven-segment code decoder
// Maps one display byte to a character code and its decimal point flag.
// ----------------------------------------------------------------------------
module sdfd_seg_decode (
    input  logic [7:0]         code,
    output sdfd_pkg::seg_dec_t dec
);

    // Table lookup; codes outside the table are unknown with no point.
    always_comb begin
        dec.point = 1'b0;
        dec.ch    = sdfd_pkg::CH_UNKNOWN;
        unique case (code)
            8'hee: dec.ch = 5'd0;
            8'hfe: begin dec.ch = 5'd0; dec.point = 1'b1; end
            8'h0a: dec.ch = 5'd1;
            8'h1a: begin dec.ch = 5'd1; dec.point = 1'b1; end
            8'h67: dec.ch = 5'd2;
            8'h77: begin dec.ch = 5'd2; dec.point = 1'b1; end
            8'h4f: dec.ch = 5'd3;
            8'h5f: begin dec.ch = 5'd3; dec.point = 1'b1; end
            8'h8b: dec.ch = 5'd4;
            8'h9b: begin dec.ch = 5'd4; dec.point = 1'b1; end
            8'hcd: dec.ch = 5'd5;
            8'hdd: begin dec.ch = 5'd5; dec.point = 1'b1; end
            8'hed: dec.ch = 5'd6;
            8'hfd: begin dec.ch = 5'd6; dec.point = 1'b1; end
            8'h0e: dec.ch = 5'd7;
            8'h1e: begin dec.ch = 5'd7; dec.point = 1'b1; end
            8'hef: dec.ch = 5'd8;
            8'hff: begin dec.ch = 5'd8; dec.point = 1'b1; end
            8'hcf: dec.ch = 5'd9;
            8'hdf: begin dec.ch = 5'd9; dec.point = 1'b1; end
            8'haf: dec.ch = 5'd10;
            8'he9: dec.ch = 5'd11;
            8'he4: dec.ch = 5'd12;
            8'h6b: dec.ch = 5'd13;
            8'he5: dec.ch = 5'd14;
            8'ha5: dec.ch = 5'd15;
            8'h68: dec.ch = sdfd_pkg::CH_U;
            8'h69: dec.ch = sdfd_pkg::CH_O;
            8'h01: dec.ch = sdfd_pkg::CH_DASH;
            8'h11: begin dec.ch = sdfd_pkg::CH_DASH; dec.point = 1'b1; end
            8'h29: dec.ch = sdfd_pkg::CH_N;
            8'he0: dec.ch = sdfd_pkg::CH_L;
            8'h41: dec.ch = sdfd_pkg::CH_EQUAL;
            8'h00: dec.ch = sdfd_pkg::CH_BLANK;
            8'h10: begin dec.ch = sdfd_pkg::CH_BLANK; dec.point = 1'b1; end
            default: begin
                dec.ch    = sdfd_pkg::CH_UNKNOWN;
                dec.point = 1'b0;
            end
        endcase
    end

endmodule
